>>> design/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg: shared types and constants of the format specification parser
// Character codes, the parse phase encoding, the flag word and the result word.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // characters recognized by the parser
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_BIG_L = 8'h4C;

    // sign mode codes
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_SPACE = 2'd1;
    localparam logic [1:0] SIGN_PLUS  = 2'd2;

    // length modifier codes
    localparam logic [3:0] LEN_NONE = 4'd0;
    localparam logic [3:0] LEN_HH   = 4'd1;
    localparam logic [3:0] LEN_H    = 4'd2;
    localparam logic [3:0] LEN_L    = 4'd3;
    localparam logic [3:0] LEN_LL   = 4'd4;
    localparam logic [3:0] LEN_J    = 4'd5;
    localparam logic [3:0] LEN_Z    = 4'd6;
    localparam logic [3:0] LEN_T    = 4'd7;
    localparam logic [3:0] LEN_BIGL = 4'd8;

    // parse phase, one-hot
    typedef enum logic [6:0] {
        PH_FLAGS    = 7'b0000001,
        PH_WIDTH    = 7'b0000010,
        PH_AFTER_W  = 7'b0000100,
        PH_PREC     = 7'b0001000,
        PH_AFTER_P  = 7'b0010000,
        PH_LEN_PEND = 7'b0100000,
        PH_LEN_DONE = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       hash;
        logic [1:0] sign;
        logic       left;
        logic       zero;
    } spec_flags_t;

    typedef struct packed {
        logic        alternate_form;
        logic [1:0]  sign_mode;
        logic        left_align;
        logic        zero_pad;
        logic [15:0] field_width;
        logic        precision_given;
        logic [15:0] precision_value;
        logic [3:0]  length_code;
        logic [7:0]  conversion;
    } spec_result_t;

endpackage

>>> design/fsp_step.sv
// ----------------------------------------------------------------------------
// fsp_step: next-state logic of the format specification parser
// Classifies one character against the current phase, updates flags, width,
// precision and length, and builds the result word on the conversion character.
// ----------------------------------------------------------------------------
module fsp_step
    import fsp_pkg::*;
#(
    parameter int NUM_BITS = 16
) (
    input  phase_t               phase_i,
    input  spec_flags_t          flags_i,
    input  logic [NUM_BITS-1:0]  width_acc_i,
    input  logic [NUM_BITS-1:0]  prec_acc_i,
    input  logic                 prec_seen_i,
    input  logic [3:0]           len_i,
    input  logic [7:0]           character,
    input  logic signed [31:0]   star_value,
    output phase_t               phase_next,
    output spec_flags_t          flags_next,
    output logic [NUM_BITS-1:0]  width_acc_next,
    output logic [NUM_BITS-1:0]  prec_acc_next,
    output logic                 prec_seen_next,
    output logic [3:0]           len_next,
    output logic                 emit,
    output spec_result_t         result
);

    localparam logic [NUM_BITS-1:0] ACC_MAX   = {NUM_BITS{1'b1}};
    localparam logic [31:0]         ACC_MAX32 = 32'(ACC_MAX);

    // value*10 + digit, saturating
    function automatic logic [NUM_BITS-1:0] acc_digit(
        input logic [NUM_BITS-1:0] v,
        input logic [3:0]          d
    );
        logic [NUM_BITS+3:0] ext;
        logic [NUM_BITS+3:0] sum;
        ext = {4'b0000, v};
        sum = (ext << 3) + (ext << 1) + {{NUM_BITS{1'b0}}, d};
        if (sum[NUM_BITS+3:NUM_BITS] != 4'b0000) begin
            acc_digit = ACC_MAX;
        end else begin
            acc_digit = sum[NUM_BITS-1:0];
        end
    endfunction

    logic                is_digit;
    logic                is_flag;
    logic                in_width_grp;
    logic                in_dot_grp;
    logic                in_len_grp;
    logic                star_neg;
    logic [NUM_BITS-1:0] star_mag;
    logic [NUM_BITS-1:0] digit_w;
    logic [NUM_BITS-1:0] digit_p;
    logic [31:0]         width_ext;
    logic [31:0]         prec_ext;
    logic [3:0]          len_one;
    logic                len_pend_one;
    logic                is_len_one;

    // character classes and phase groups
    assign is_digit     = (character >= CH_ZERO) && (character <= CH_NINE);
    assign is_flag      = (character == CH_HASH) || (character == CH_SPACE) ||
                          (character == CH_PLUS) || (character == CH_MINUS) ||
                          (character == CH_ZERO);
    assign in_width_grp = (phase_i == PH_FLAGS) || (phase_i == PH_WIDTH);
    assign in_dot_grp   = in_width_grp || (phase_i == PH_AFTER_W);
    assign in_len_grp   = in_dot_grp || (phase_i == PH_PREC) || (phase_i == PH_AFTER_P);

    // star argument magnitude, negative gives zero
    assign star_neg = star_value[31];
    always_comb begin
        if (star_neg) begin
            star_mag = '0;
        end else if ($unsigned(star_value) > ACC_MAX32) begin
            star_mag = ACC_MAX;
        end else begin
            star_mag = star_value[NUM_BITS-1:0];
        end
    end

    assign digit_w = acc_digit(width_acc_i, character[3:0]);
    assign digit_p = acc_digit(prec_acc_i, character[3:0]);

    // first length letter
    always_comb begin
        is_len_one   = 1'b1;
        len_pend_one = 1'b0;
        len_one      = LEN_NONE;
        case (character)
            CH_H: begin
                len_one      = LEN_H;
                len_pend_one = 1'b1;
            end
            CH_L: begin
                len_one      = LEN_L;
                len_pend_one = 1'b1;
            end
            CH_J:     len_one = LEN_J;
            CH_Z:     len_one = LEN_Z;
            CH_T:     len_one = LEN_T;
            CH_BIG_L: len_one = LEN_BIGL;
            default:  is_len_one = 1'b0;
        endcase
    end

    // phase step
    always_comb begin
        phase_next     = phase_i;
        flags_next     = flags_i;
        width_acc_next = width_acc_i;
        prec_acc_next  = prec_acc_i;
        prec_seen_next = prec_seen_i;
        len_next       = len_i;
        emit           = 1'b0;
        if ((phase_i == PH_FLAGS) && is_flag) begin
            case (character)
                CH_HASH:  flags_next.hash = 1'b1;
                CH_SPACE: flags_next.sign = SIGN_SPACE;
                CH_PLUS:  flags_next.sign = SIGN_PLUS;
                CH_MINUS: begin
                    flags_next.left = 1'b1;
                    flags_next.zero = 1'b0;
                end
                default:  flags_next.zero = !flags_i.left;
            endcase
        end else if (in_width_grp && is_digit) begin
            width_acc_next = digit_w;
            phase_next     = PH_WIDTH;
        end else if (in_width_grp && (character == CH_STAR)) begin
            width_acc_next = star_mag;
            phase_next     = PH_AFTER_W;
        end else if (in_dot_grp && (character == CH_DOT)) begin
            prec_seen_next = 1'b1;
            prec_acc_next  = '0;
            phase_next     = PH_PREC;
        end else if ((phase_i == PH_PREC) && is_digit) begin
            prec_acc_next = digit_p;
        end else if ((phase_i == PH_PREC) && (character == CH_STAR)) begin
            prec_acc_next = star_mag;
            if (star_neg) begin
                prec_seen_next = 1'b0;
            end
            phase_next = PH_AFTER_P;
        end else if (in_len_grp && is_len_one) begin
            len_next   = len_one;
            phase_next = len_pend_one ? PH_LEN_PEND : PH_LEN_DONE;
        end else if ((phase_i == PH_LEN_PEND) &&
                     (((character == CH_H) && (len_i == LEN_H)) ||
                      ((character == CH_L) && (len_i == LEN_L)))) begin
            len_next   = (character == CH_H) ? LEN_HH : LEN_LL;
            phase_next = PH_LEN_DONE;
        end else begin
            // conversion character: emit and start over
            emit           = 1'b1;
            phase_next     = PH_FLAGS;
            flags_next     = '{hash: 1'b0, sign: SIGN_NONE, left: 1'b0, zero: 1'b0};
            width_acc_next = '0;
            prec_acc_next  = '0;
            prec_seen_next = 1'b0;
            len_next       = LEN_NONE;
        end
    end

    // result word from the state before this character
    assign width_ext = 32'(width_acc_i);
    assign prec_ext  = 32'(prec_acc_i);

    always_comb begin
        result.alternate_form  = flags_i.hash;
        result.sign_mode       = flags_i.sign;
        result.left_align      = flags_i.left;
        result.zero_pad        = flags_i.zero;
        result.field_width     = width_ext[15:0];
        result.precision_given = prec_seen_i;
        result.precision_value = prec_seen_i ? prec_ext[15:0] : 16'd0;
        result.length_code     = len_i;
        result.conversion      = character;
    end

endmodule

>>> design/format_spec_parser_top.sv
// ----------------------------------------------------------------------------
// format_spec_parser_top: printf-style conversion specification parser
// Takes the characters after a percent sign one word at a time and emits the
// parsed specification when the conversion character arrives.
// ----------------------------------------------------------------------------
// path: an accepted word goes through the input register, then the result
//   register raises m_valid
// throughput: one word per cycle; the input stalls only when a conversion word
//   meets a result register that is full and not being taken
// reset: synchronous active-low aresetn empties both registers and returns the
//   parser to the flags phase with all flags, width, precision and length cleared
module format_spec_parser_top
    import fsp_pkg::*;
#(
    parameter int NUM_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_character,
    input  logic signed [31:0] s_star_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_alternate_form,
    output logic [1:0]         m_sign_mode,
    output logic               m_left_align,
    output logic               m_zero_pad,
    output logic [15:0]        m_field_width,
    output logic               m_precision_given,
    output logic [15:0]        m_precision_value,
    output logic [3:0]         m_length_code,
    output logic [7:0]         m_conversion
);

    logic               in_valid_reg;
    logic [7:0]         char_reg;
    logic signed [31:0] star_reg;

    phase_t              phase_reg;
    spec_flags_t         flags_reg;
    logic [NUM_BITS-1:0] width_acc_reg;
    logic [NUM_BITS-1:0] prec_acc_reg;
    logic                prec_seen_reg;
    logic [3:0]          len_reg;

    phase_t              phase_next;
    spec_flags_t         flags_next;
    logic [NUM_BITS-1:0] width_acc_next;
    logic [NUM_BITS-1:0] prec_acc_next;
    logic                prec_seen_next;
    logic [3:0]          len_next;
    logic                step_emit;
    spec_result_t        step_result;

    logic                m_valid_reg;
    spec_result_t        result_reg;
    logic                advance;

    fsp_step #(
        .NUM_BITS(NUM_BITS)
    ) u_step (
        .phase_i        (phase_reg),
        .flags_i        (flags_reg),
        .width_acc_i    (width_acc_reg),
        .prec_acc_i     (prec_acc_reg),
        .prec_seen_i    (prec_seen_reg),
        .len_i          (len_reg),
        .character      (char_reg),
        .star_value     (star_reg),
        .phase_next     (phase_next),
        .flags_next     (flags_next),
        .width_acc_next (width_acc_next),
        .prec_acc_next  (prec_acc_next),
        .prec_seen_next (prec_seen_next),
        .len_next       (len_next),
        .emit           (step_emit),
        .result         (step_result)
    );

    // a held word moves on unless it emits into a full, untaken result register
    assign advance = in_valid_reg && (!step_emit || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_character;
            star_reg <= s_star_value;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FLAGS;
            flags_reg     <= '{hash: 1'b0, sign: SIGN_NONE, left: 1'b0, zero: 1'b0};
            width_acc_reg <= '0;
            prec_acc_reg  <= '0;
            prec_seen_reg <= 1'b0;
            len_reg       <= LEN_NONE;
        end else if (advance) begin
            phase_reg     <= phase_next;
            flags_reg     <= flags_next;
            width_acc_reg <= width_acc_next;
            prec_acc_reg  <= prec_acc_next;
            prec_seen_reg <= prec_seen_next;
            len_reg       <= len_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && step_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_emit) begin
            result_reg <= step_result;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_alternate_form  = result_reg.alternate_form;
    assign m_sign_mode       = result_reg.sign_mode;
    assign m_left_align      = result_reg.left_align;
    assign m_zero_pad        = result_reg.zero_pad;
    assign m_field_width     = result_reg.field_width;
    assign m_precision_given = result_reg.precision_given;
    assign m_precision_value = result_reg.precision_value;
    assign m_length_code     = result_reg.length_code;
    assign m_conversion      = result_reg.conversion;

    // checks
    a_restart_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_emit |=> phase_reg == PH_FLAGS && len_reg == LEN_NONE)
        else $error("parser did not restart after a conversion word");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !(advance && step_emit))
        else $error("pending result overwritten");

    a_left_excludes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !(flags_reg.left && flags_reg.zero))
        else $error("zero padding set while left aligned");

    a_prec_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !prec_seen_reg |-> prec_acc_reg == '0)
        else $error("precision value held without precision");

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the format specification parser
// Drives conversion specifications one character word at a time. A directed
// table with hand-written results comes first, then random specifications and
// stray bytes. Results are checked against the table or an in-bench model, with
// random idling on both channels, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
    import fsp_pkg::*;

    typedef struct {
        logic [7:0]         ch;
        logic signed [31:0] star;
        bit                 typed;
        spec_result_t       spec;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_character;
    logic signed [31:0] s_star_value;
    logic               m_valid;
    logic               m_ready;
    logic               m_alternate_form;
    logic [1:0]         m_sign_mode;
    logic               m_left_align;
    logic               m_zero_pad;
    logic [15:0]        m_field_width;
    logic               m_precision_given;
    logic [15:0]        m_precision_value;
    logic [3:0]         m_length_code;
    logic [7:0]         m_conversion;

    // parser model state
    phase_t      cur_phase;
    spec_flags_t cur_flags;
    logic [15:0] cur_width;
    logic [15:0] cur_prec;
    logic        cur_prec_seen;
    logic [3:0]  cur_len;

    spec_result_t expected_specs[$];
    stim_row_t    burst[$];

    int           mismatches = 0;
    int           specs_checked = 0;
    int           words_sent = 0;
    bit           tx_steady = 1'b0;
    bit           rx_held = 1'b0;
    bit           row_typed = 1'b0;
    spec_result_t row_spec = '0;

    format_spec_parser_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_character       (s_character),
        .s_star_value      (s_star_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_alternate_form  (m_alternate_form),
        .m_sign_mode       (m_sign_mode),
        .m_left_align      (m_left_align),
        .m_zero_pad        (m_zero_pad),
        .m_field_width     (m_field_width),
        .m_precision_given (m_precision_given),
        .m_precision_value (m_precision_value),
        .m_length_code     (m_length_code),
        .m_conversion      (m_conversion)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    task automatic clear_spec();
        cur_phase     = PH_FLAGS;
        cur_flags     = '0;
        cur_width     = '0;
        cur_prec      = '0;
        cur_prec_seen = 1'b0;
        cur_len       = LEN_NONE;
    endtask

    // decimal digit into an accumulator, saturating at 16 bits
    function automatic logic [15:0] next_digit(logic [15:0] acc, logic [7:0] c);
        int unsigned n;
        n = acc * 10 + (c - CH_ZERO);
        next_digit = (n > 32'd65535) ? 16'hFFFF : n[15:0];
    endfunction

    // star argument: negative gives 0, large values saturate
    function automatic logic [15:0] star_clip(logic signed [31:0] sv);
        if (sv < 0)
            star_clip = '0;
        else if (sv > 32'sd65535)
            star_clip = 16'hFFFF;
        else
            star_clip = sv[15:0];
    endfunction

    // length letters; h and l wait for a possible second letter
    function automatic bit take_length(logic [7:0] c);
        take_length = 1'b1;
        case (c)
            CH_H: begin
                cur_len   = LEN_H;
                cur_phase = PH_LEN_PEND;
            end
            CH_L: begin
                cur_len   = LEN_L;
                cur_phase = PH_LEN_PEND;
            end
            CH_J: begin
                cur_len   = LEN_J;
                cur_phase = PH_LEN_DONE;
            end
            CH_Z: begin
                cur_len   = LEN_Z;
                cur_phase = PH_LEN_DONE;
            end
            CH_T: begin
                cur_len   = LEN_T;
                cur_phase = PH_LEN_DONE;
            end
            CH_BIG_L: begin
                cur_len   = LEN_BIGL;
                cur_phase = PH_LEN_DONE;
            end
            default: take_length = 1'b0;
        endcase
    endfunction

    task automatic parse_word(input logic [7:0] c, input logic signed [31:0] sv,
                              output bit emit, output spec_result_t r);
        phase_t ph;
        bit     taken;
        ph    = cur_phase;
        taken = 1'b0;
        emit  = 1'b0;
        r     = '0;
        // flags; a zero after a minus is ignored
        if (ph == PH_FLAGS) begin
            taken = 1'b1;
            case (c)
                CH_HASH:  cur_flags.hash = 1'b1;
                CH_SPACE: cur_flags.sign = SIGN_SPACE;
                CH_PLUS:  cur_flags.sign = SIGN_PLUS;
                CH_MINUS: begin
                    cur_flags.left = 1'b1;
                    cur_flags.zero = 1'b0;
                end
                CH_ZERO:  if (!cur_flags.left) cur_flags.zero = 1'b1;
                default:  taken = 1'b0;
            endcase
        end
        // width digits or star
        if (!taken && (ph == PH_FLAGS || ph == PH_WIDTH)) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                cur_width = next_digit(cur_width, c);
                cur_phase = PH_WIDTH;
                taken     = 1'b1;
            end else if (c == CH_STAR) begin
                cur_width = star_clip(sv);
                cur_phase = PH_AFTER_W;
                taken     = 1'b1;
            end
        end
        // dot or length once the width is over
        if (!taken && (ph == PH_FLAGS || ph == PH_WIDTH || ph == PH_AFTER_W)) begin
            if (c == CH_DOT) begin
                cur_prec_seen = 1'b1;
                cur_prec      = '0;
                cur_phase     = PH_PREC;
                taken         = 1'b1;
            end else begin
                taken = take_length(c);
            end
        end
        // precision digits or star
        if (!taken && ph == PH_PREC) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                cur_prec = next_digit(cur_prec, c);
                taken    = 1'b1;
            end else if (c == CH_STAR) begin
                cur_prec = star_clip(sv);
                if (sv < 0)
                    cur_prec_seen = 1'b0;
                cur_phase = PH_AFTER_P;
                taken     = 1'b1;
            end
        end
        if (!taken && (ph == PH_PREC || ph == PH_AFTER_P))
            taken = take_length(c);
        // pending h or l doubles up
        if (!taken && ph == PH_LEN_PEND) begin
            if ((c == CH_H && cur_len == LEN_H) || (c == CH_L && cur_len == LEN_L)) begin
                cur_len   = (c == CH_H) ? LEN_HH : LEN_LL;
                cur_phase = PH_LEN_DONE;
                taken     = 1'b1;
            end
        end
        // anything else is the conversion character
        if (!taken) begin
            emit              = 1'b1;
            r.alternate_form  = cur_flags.hash;
            r.sign_mode       = cur_flags.sign;
            r.left_align      = cur_flags.left;
            r.zero_pad        = cur_flags.zero;
            r.field_width     = cur_width;
            r.precision_given = cur_prec_seen;
            r.precision_value = cur_prec_seen ? cur_prec : 16'h0000;
            r.length_code     = cur_len;
            r.conversion      = c;
            clear_spec();
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic spec_result_t make_spec(logic alt, logic [1:0] sg, logic left,
                                               logic zero, logic [15:0] w, logic pg,
                                               logic [15:0] pv, logic [3:0] len,
                                               logic [7:0] conv);
        make_spec = {alt, sg, left, zero, w, pg, pv, len, conv};
    endfunction

    function automatic logic signed [31:0] rand_star();
        case ($urandom_range(5))
            0:       rand_star = $urandom_range(0, 99);
            1:       rand_star = $urandom;
            2:       rand_star = -int'($urandom_range(1, 50));
            3:       rand_star = 65534 + $urandom_range(0, 2);
            4:       rand_star = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: rand_star = $urandom_range(0, 70000);
        endcase
    endfunction

    task automatic push_word(input logic [7:0] c, input logic signed [31:0] sv);
        stim_row_t w;
        w.ch    = c;
        w.star  = sv;
        w.typed = 1'b0;
        w.spec  = '0;
        burst.push_back(w);
    endtask

    // mostly short digit runs, now and then long enough to saturate
    task automatic push_digits();
        int n;
        n = ($urandom_range(7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        repeat (n) push_word(8'(CH_ZERO + $urandom_range(9)), $urandom);
    endtask

    // one random specification, or a run of stray bytes
    task automatic build_burst();
        int         n;
        logic [7:0] c;
        string      conv_set;
        string      parser_chars;
        burst.delete();
        conv_set     = "diouxXcspfeEgGaAn%";
        parser_chars = "#-+ 0123456789*.hljztL";
        if ($urandom_range(99) < 15) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(1))
                    c = 8'($urandom_range(255));
                else
                    c = parser_chars[$urandom_range(parser_chars.len() - 1)];
                push_word(c, (c == CH_STAR) ? rand_star() : $urandom);
            end
        end else begin
            // flags
            n = $urandom_range(0, 3);
            repeat (n) begin
                case ($urandom_range(4))
                    0:       c = CH_HASH;
                    1:       c = CH_MINUS;
                    2:       c = CH_SPACE;
                    3:       c = CH_PLUS;
                    default: c = CH_ZERO;
                endcase
                push_word(c, $urandom);
            end
            // width
            case ($urandom_range(4))
                0: ;
                1, 4: push_digits();
                2: push_word(CH_STAR, rand_star());
                default: begin
                    push_digits();
                    push_word(CH_STAR, rand_star());
                end
            endcase
            // precision
            if ($urandom_range(1)) begin
                push_word(CH_DOT, $urandom);
                case ($urandom_range(3))
                    0: ;
                    1: push_digits();
                    2: push_word(CH_STAR, rand_star());
                    default: begin
                        push_digits();
                        push_word(CH_STAR, rand_star());
                    end
                endcase
            end
            // length modifier
            case ($urandom_range(9))
                2: push_word(CH_H, $urandom);
                3: begin
                    push_word(CH_H, $urandom);
                    push_word(CH_H, $urandom);
                end
                4: push_word(CH_L, $urandom);
                5: begin
                    push_word(CH_L, $urandom);
                    push_word(CH_L, $urandom);
                end
                6: push_word(CH_J, $urandom);
                7: push_word(CH_Z, $urandom);
                8: push_word(CH_T, $urandom);
                9: push_word(CH_BIG_L, $urandom);
                default: ;
            endcase
            // conversion, now and then any byte at all
            if ($urandom_range(19) == 0)
                c = 8'($urandom_range(255));
            else
                c = conv_set[$urandom_range(conv_set.len() - 1)];
            push_word(c, (c == CH_STAR) ? rand_star() : $urandom);
        end
    endtask

    // present one word at the falling edge, return once it is taken
    task automatic send_word(input stim_row_t w);
        @(negedge aclk);
        while (!tx_steady && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_character  <= w.ch;
        s_star_value <= w.star;
        row_typed     = w.typed;
        row_spec      = w.spec;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // input side: every accepted word goes through the model
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : word_monitor
        bit           emit;
        spec_result_t r;
        if (aresetn && s_valid && s_ready) begin
            parse_word(s_character, s_star_value, emit, r);
            if (row_typed)
                expected_specs.push_back(row_spec);
            else if (emit)
                expected_specs.push_back(r);
            words_sent++;
        end
    end

    // output side: compare each result with the oldest expectation
    always @(posedge aclk) begin : spec_monitor
        spec_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_specs.size() == 0) begin
                $error("result with nothing expected, conversion %0h", m_conversion);
                mismatches++;
            end else begin
                want = expected_specs.pop_front();
                check_field("alternate_form", 16'(want.alternate_form),
                            16'(m_alternate_form));
                check_field("sign_mode", 16'(want.sign_mode), 16'(m_sign_mode));
                check_field("left_align", 16'(want.left_align), 16'(m_left_align));
                check_field("zero_pad", 16'(want.zero_pad), 16'(m_zero_pad));
                check_field("field_width", want.field_width, m_field_width);
                check_field("precision_given", 16'(want.precision_given),
                            16'(m_precision_given));
                check_field("precision_value", want.precision_value, m_precision_value);
                check_field("length_code", 16'(want.length_code), 16'(m_length_code));
                check_field("conversion", 16'(want.conversion), 16'(m_conversion));
            end
            specs_checked++;
        end
    end

    // receiver: random stalls, one long hold-off, one window with no stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!rx_held && specs_checked >= 60) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                rx_held = 1'b1;
            end
            m_ready <= (specs_checked >= 120 && specs_checked < 170) ||
                       ($urandom_range(99) >= 34);
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        stim_row_t spec_table[$];
        stim_row_t w;
        int        random_words;
        bit        drained;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_character  = '0;
        s_star_value = '0;
        random_words = 0;
        drained      = 1'b0;
        clear_spec();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table; the last word of each specification carries its result
        w.typed = 1'b0;
        w.spec  = '0;
        // bare conversion right after reset
        w.ch = "d"; w.star = 0; w.typed = 1'b1;
        w.spec = make_spec(1'b0, SIGN_NONE, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0,
                           LEN_NONE, "d");
        spec_table.push_back(w);
        w.typed = 1'b0;
        // all flags: the later plus replaces space, zero after minus is ignored
        w.ch = CH_HASH;  w.star = 32'sh7FFF_FFFF; spec_table.push_back(w);
        w.ch = CH_SPACE; w.star = 32'sh8000_0000; spec_table.push_back(w);
        w.ch = CH_PLUS;  w.star = -1;             spec_table.push_back(w);
        w.ch = CH_MINUS; w.star = 0;              spec_table.push_back(w);
        w.ch = CH_ZERO;  w.star = 0;              spec_table.push_back(w);
        w.ch = "x"; w.star = 0; w.typed = 1'b1;
        w.spec = make_spec(1'b1, SIGN_PLUS, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0,
                           LEN_NONE, "x");
        spec_table.push_back(w);
        w.typed = 1'b0;
        // leading zero flag, star replaces digits, negative star precision, lone h
        w.ch = CH_ZERO; w.star = 0;             spec_table.push_back(w);
        w.ch = "9";     w.star = 0;             spec_table.push_back(w);
        w.ch = CH_STAR; w.star = 32'sh7FFF_FFFF; spec_table.push_back(w);
        w.ch = CH_DOT;  w.star = 0;             spec_table.push_back(w);
        w.ch = CH_STAR; w.star = -1;            spec_table.push_back(w);
        w.ch = CH_H;    w.star = 0;             spec_table.push_back(w);
        w.ch = "c"; w.star = 0; w.typed = 1'b1;
        w.spec = make_spec(1'b0, SIGN_NONE, 1'b0, 1'b1, 16'hFFFF, 1'b0, 16'd0,
                           LEN_H, "c");
        spec_table.push_back(w);
        w.typed = 1'b0;
        // most negative star width, saturating precision digits, ll then a late l
        w.ch = CH_STAR; w.star = 32'sh8000_0000; spec_table.push_back(w);
        w.ch = CH_DOT;  w.star = 0;              spec_table.push_back(w);
        w.ch = "9";
        repeat (5) spec_table.push_back(w);
        w.ch = CH_L; spec_table.push_back(w);
        spec_table.push_back(w);
        w.typed = 1'b1;
        w.spec = make_spec(1'b0, SIGN_NONE, 1'b0, 1'b0, 16'd0, 1'b1, 16'hFFFF,
                           LEN_LL, CH_L);
        spec_table.push_back(w);
        w.typed = 1'b0;
        // a digit after a width star ends the specification
        w.ch = "7";     w.star = 0;  spec_table.push_back(w);
        w.ch = CH_STAR; w.star = 12; spec_table.push_back(w);
        w.ch = "3"; w.star = 0; w.typed = 1'b1;
        w.spec = make_spec(1'b0, SIGN_NONE, 1'b0, 1'b0, 16'd12, 1'b0, 16'd0,
                           LEN_NONE, "3");
        spec_table.push_back(w);

        foreach (spec_table[i]) send_word(spec_table[i]);

        // random specifications and stray bytes
        while (random_words < 1750) begin
            build_burst();
            foreach (burst[i]) begin
                send_word(burst[i]);
                random_words++;
                tx_steady = (random_words >= 500 && random_words < 800);
                // one pause until every pending result is out
                if (!drained && random_words >= 1100) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                    while (expected_specs.size() != 0) @(negedge aclk);
                    drained = 1'b1;
                end
            end
        end

        // drain
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_specs.size() != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);

        $display("sent %0d words (%0d from the table), checked %0d specifications",
                 words_sent, spec_table.size(), specs_checked);
        $display("flags, widths, precisions, stars, length letters and stray bytes, "
                 , "with idling, a long output stall and a drain pause");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
